>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the range inversion bit store.
// No dependencies; include this header in modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/ribs_pkg.sv
// Package for the range inversion bit store: transaction types, codes, states.
// No dependencies.
`default_nettype none
package ribs_pkg;

  localparam int unsigned POS_W = 11;
  localparam logic [POS_W-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_INVERT = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INV_STEP,
    ST_INV_WR,
    ST_QRY_RD,
    ST_QRY_ACC
  } state_e;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] lo_pos;
    logic [POS_W-1:0] hi_pos;
    logic             load_bit;
  } req_t;

  typedef struct packed {
    logic value;
    logic in_range;
  } rsp_t;

endpackage
`default_nettype wire

>>> src/ribs_ram.sv
// Single-bit synchronous RAM, one write and one read port, registered read data.
// No dependencies.
`default_nettype none
module ribs_ram #(
  parameter int unsigned DEPTH = 2048
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire                       wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic                      rdata_o
);

  logic mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> src/range_invert_bit_store.sv
// Range inversion bit store: parity tags on a bottom-up segment tree in RAM.
// One transaction at a time. Load writes the bit RAM directly. Query walks from the leaf to the
// root, reading each tag, and strobes the result; out of range, the strobe comes in the cycle after
// the request is accepted. Invert walks the tree level by level, reading then toggling each covered
// node (two at most a level). Reset, clear and a length write in idle sweep the tag RAM, busy
// high. Results cannot stall. Depends on ribs_pkg, ribs_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module range_invert_bit_store #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire ribs_pkg::req_t           req_i,
  output logic                          valid_o,
  output ribs_pkg::rsp_t                rsp_o,
  input  wire                           cfg_we_i,
  input  wire [ribs_pkg::POS_W-1:0]     cfg_wdata_i
);

  localparam int unsigned L   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned NW  = L + 1;
  localparam int unsigned XW  = L + 2;
  localparam int unsigned PW  = $clog2(MAX_LEN + 1);
  localparam int unsigned CW  = (PW > ribs_pkg::POS_W) ? PW : ribs_pkg::POS_W;
  localparam int unsigned B   = 1 << L;

  ribs_pkg::state_e state_q, state_d;
  logic [ribs_pkg::POS_W-1:0] len_q;
  logic [XW-1:0] l_q, l_d, r_q, r_d;
  logic [NW-1:0] cur_q, cur_d, clr_q, clr_d;
  logic          acc_q, acc_d;
  logic          valid_q, valid_d;
  ribs_pkg::rsp_t rsp_q, rsp_d;

  logic [CW-1:0] n, lo_c, hi_c, p, q;
  logic          lo_ok, inv_ok, accept;

  logic          tag_we, tag_wdata, tag_re, tag_rdata;
  logic [NW-1:0] tag_waddr, tag_raddr;
  logic          bit_re, bit_rdata;
  logic [L-1:0]  bit_addr;

  // range decode of the incoming transaction
  always_comb begin
    n      = (CW'(len_q) > CW'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(len_q);
    lo_c   = CW'(req_i.lo_pos);
    hi_c   = CW'(req_i.hi_pos);
    lo_ok  = (lo_c != '0) && (lo_c <= n);
    p      = (lo_c == '0) ? CW'(1) : lo_c;
    q      = (hi_c > n) ? n : hi_c;
    inv_ok = (n != '0) && (p <= q);
    accept = start && !busy;
    bit_addr = L'(lo_c - CW'(1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ribs_pkg::ST_IDLE: begin
        if (cfg_we_i) begin
          state_d = ribs_pkg::ST_CLEAR;
        end else if (accept) begin
          unique case (req_i.kind)
            ribs_pkg::KIND_INVERT: if (inv_ok) state_d = ribs_pkg::ST_INV_STEP;
            ribs_pkg::KIND_QUERY:  if (lo_ok) state_d = ribs_pkg::ST_QRY_RD;
            ribs_pkg::KIND_CLEAR:  state_d = ribs_pkg::ST_CLEAR;
            default:               state_d = ribs_pkg::ST_IDLE;
          endcase
        end
      end
      ribs_pkg::ST_CLEAR: begin
        if (clr_q == '1) state_d = ribs_pkg::ST_IDLE;
      end
      ribs_pkg::ST_INV_STEP: begin
        if (l_q >= r_q) begin
          state_d = ribs_pkg::ST_IDLE;
        end else if (l_q[0] || r_q[0]) begin
          state_d = ribs_pkg::ST_INV_WR;
        end
      end
      ribs_pkg::ST_INV_WR: state_d = ribs_pkg::ST_INV_STEP;
      ribs_pkg::ST_QRY_RD: state_d = ribs_pkg::ST_QRY_ACC;
      ribs_pkg::ST_QRY_ACC: begin
        state_d = (cur_q == NW'(1)) ? ribs_pkg::ST_IDLE : ribs_pkg::ST_QRY_RD;
      end
      default: state_d = ribs_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    l_d       = l_q;
    r_d       = r_q;
    cur_d     = cur_q;
    clr_d     = clr_q;
    acc_d     = acc_q;
    valid_d   = 1'b0;
    rsp_d     = rsp_q;
    tag_we    = 1'b0;
    tag_waddr = cur_q;
    tag_wdata = 1'b0;
    tag_re    = 1'b0;
    tag_raddr = cur_q;
    bit_re    = 1'b0;
    unique case (state_q)
      ribs_pkg::ST_IDLE: begin
        clr_d = '0;
        if (!cfg_we_i && accept) begin
          // walk bounds: leaves at B, right bound exclusive
          l_d   = XW'(B) + XW'(p) - XW'(1);
          r_d   = XW'(B) + XW'(q);
          cur_d = NW'(B) + NW'(lo_c) - NW'(1);
          acc_d = 1'b0;
          bit_re = (req_i.kind == ribs_pkg::KIND_QUERY) && lo_ok;
          if (req_i.kind == ribs_pkg::KIND_QUERY && !lo_ok) begin
            valid_d = 1'b1;
            rsp_d   = '{value: 1'b0, in_range: 1'b0};
          end
        end
      end
      ribs_pkg::ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_q;
        clr_d     = clr_q + NW'(1);
      end
      ribs_pkg::ST_INV_STEP: begin
        if (l_q < r_q) begin
          if (l_q[0]) begin
            tag_re    = 1'b1;
            tag_raddr = NW'(l_q);
            cur_d     = NW'(l_q);
            l_d       = l_q + XW'(1);
          end else if (r_q[0]) begin
            tag_re    = 1'b1;
            tag_raddr = NW'(r_q - XW'(1));
            cur_d     = NW'(r_q - XW'(1));
            r_d       = r_q - XW'(1);
          end else begin
            l_d = l_q >> 1;
            r_d = r_q >> 1;
          end
        end
      end
      ribs_pkg::ST_INV_WR: begin
        // toggle the node read last cycle
        tag_we    = 1'b1;
        tag_waddr = cur_q;
        tag_wdata = ~tag_rdata;
      end
      ribs_pkg::ST_QRY_RD: begin
        tag_re    = 1'b1;
        tag_raddr = cur_q;
      end
      ribs_pkg::ST_QRY_ACC: begin
        acc_d = acc_q ^ tag_rdata;
        cur_d = cur_q >> 1;
        if (cur_q == NW'(1)) begin
          valid_d = 1'b1;
          rsp_d   = '{value: acc_q ^ tag_rdata ^ bit_rdata, in_range: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ribs_pkg::ST_CLEAR;
      clr_q   <= '0;
      len_q   <= ribs_pkg::LEN_RESET;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    l_q   <= l_d;
    r_q   <= r_d;
    cur_q <= cur_d;
    acc_q <= acc_d;
    rsp_q <= rsp_d;
  end

  assign busy    = (state_q != ribs_pkg::ST_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // parity tags, one per tree node
  ribs_ram #(.DEPTH(2 * B)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // loaded bits
  ribs_ram #(.DEPTH(B)) u_bit_ram (
    .clk_i   (clk_i),
    .we_i    (accept && !cfg_we_i && req_i.kind == ribs_pkg::KIND_LOAD && lo_ok),
    .waddr_i (bit_addr),
    .wdata_i (req_i.load_bit),
    .re_i    (bit_re),
    .raddr_i (bit_addr),
    .rdata_o (bit_rdata)
  );

  `ASSERT_IMP(a_walk_order, clk_i, rst_ni, state_q == ribs_pkg::ST_INV_STEP, l_q <= r_q, "invert walk bounds crossed")
  `ASSERT_CLK(a_wr_follows, clk_i, rst_ni, state_q == ribs_pkg::ST_INV_WR |=> state_q == ribs_pkg::ST_INV_STEP, "toggle write not followed by walk step")
  `ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, valid_o && rsp_o.in_range, $past(busy), "in-range result without a walk")

endmodule
`default_nettype wire
